// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the brick palette material encoder.
// All checks are clocked on clk_i and muted while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge out of reset
`define BPME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define BPME_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/bpme_pkg.sv
// ---------------------------------------------------------------------------
// bpme_pkg
// Shared constants and codes of the brick palette material encoder.
// ---------------------------------------------------------------------------
package bpme_pkg;

  // Payload widths
  localparam int MAT_W = 8;              // material byte
  localparam int NIB_W = 4;              // packed palette index
  localparam int MODE_W = 2;             // encoding_mode register

  // Default palette size (slot 0 is air)
  localparam int PALETTE_SLOTS = 16;

  // Encoding modes; the unused code behaves as raw
  localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PALETTE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAW     = 2'd2;

  // Register reset values
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_PALETTE;
  localparam logic [MAT_W-1:0]  AIR_RESET  = 8'h00;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_SEL_BIT = 2;        // word address bit that picks the register
  localparam logic REG_IDX_MODE = 1'b0;
  localparam logic REG_IDX_AIR  = 1'b1;

endpackage

// File: rtl/brick_palette_material_encoder_top.sv
// ---------------------------------------------------------------------------
// brick_palette_material_encoder_top
// Encodes the material bytes of one brick as a uniform byte, raw bytes or
// packed four-bit local palette indices followed by the palette itself.
// ---------------------------------------------------------------------------
// Voxels are taken one per cycle while the output does not stall and no
// palette flush runs: an input register feeds a single pass of compare and
// pack logic that writes the output register. A byte that a voxel emits
// passes through the input register and then the output register. A brick
// that ends in palette mode is followed by PALETTE_SLOTS palette bytes, read
// one per cycle while the output does not stall, from the palette registers
// into the output register; voxels of the next brick wait until the flush
// is done.
// ---------------------------------------------------------------------------

`include "assert_macros.svh"

module brick_palette_material_encoder_top #(
  parameter int PALETTE_SLOTS = bpme_pkg::PALETTE_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // voxel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bpme_pkg::MAT_W-1:0]    material_i,
  input  logic                          occupied_i,
  input  logic                          brick_end_i,
  // encoded output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpme_pkg::MAT_W-1:0]    out_byte_o,
  output logic                          out_last_o,
  output logic                          palette_overflow_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpme_pkg::APB_AW-1:0]   paddr,
  input  logic [bpme_pkg::APB_DW-1:0]   pwdata,
  output logic [bpme_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int MAT_W  = bpme_pkg::MAT_W;
  localparam int NIB_W  = bpme_pkg::NIB_W;
  localparam int MODE_W = bpme_pkg::MODE_W;
  localparam int IDX_W  = $clog2(PALETTE_SLOTS);
  localparam int USED_W = $clog2(PALETTE_SLOTS + 1);
  localparam logic [USED_W-1:0] USED_FULL  = USED_W'(PALETTE_SLOTS);
  localparam logic [USED_W-1:0] USED_RESET = USED_W'(1);
  localparam logic [IDX_W-1:0]  FLUSH_LAST = IDX_W'(PALETTE_SLOTS - 1);

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [MAT_W-1:0]  air_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bpme_pkg::MODE_RESET;
      air_q  <= bpme_pkg::AIR_RESET;
    end else if (cfg_wr) begin
      if (paddr[bpme_pkg::REG_SEL_BIT] == bpme_pkg::REG_IDX_AIR) begin
        air_q <= pwdata[MAT_W-1:0];
      end else begin
        mode_q <= pwdata[MODE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[bpme_pkg::REG_SEL_BIT] == bpme_pkg::REG_IDX_AIR) begin
      prdata = bpme_pkg::APB_DW'(air_q);
    end else begin
      prdata = bpme_pkg::APB_DW'(mode_q);
    end
  end

  // Input register
  logic              in_v_q;
  logic [MAT_W-1:0]  in_mat_q;
  logic              in_occ_q;
  logic              in_end_q;
  logic              s1_take;

  assign in_stall_o = in_v_q && !s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_mat_q <= material_i;
      in_occ_q <= occupied_i;
      in_end_q <= brick_end_i;
    end
  end

  // Brick state
  logic [MAT_W-1:0]  table_q [PALETTE_SLOTS];
  logic [MAT_W-1:0]  table_d [PALETTE_SLOTS];
  logic [USED_W-1:0] used_q, used_d;
  logic [NIB_W-1:0]  held_q, held_d;
  logic              parity_q, parity_d;
  logic [MAT_W-1:0]  uni_q, uni_d;
  logic              ovf_q, ovf_d;
  logic              flush_q, flush_d;
  logic [IDX_W-1:0]  fcnt_q, fcnt_d;

  // Output register
  logic              out_v_q, out_v_d;
  logic [MAT_W-1:0]  out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;
  logic              out_free;

  assign out_free = !out_v_q || !out_stall_i;

  // Palette lookup: parallel compare over the live slots
  logic              is_pal;
  logic              is_air;
  logic              hit;
  logic [NIB_W-1:0]  hit_idx;
  logic              ins;
  logic              ovf_set;
  logic [NIB_W-1:0]  idx;

  assign is_pal = (mode_q == bpme_pkg::MODE_PALETTE);
  assign is_air = (in_mat_q == air_q);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = 1; k < PALETTE_SLOTS; k++) begin
      if (!hit && (USED_W'(k) < used_q) && (table_q[k] == in_mat_q)) begin
        hit     = 1'b1;
        hit_idx = NIB_W'(k);
      end
    end
  end

  always_comb begin
    ins     = 1'b0;
    ovf_set = 1'b0;
    idx     = '0;
    if (is_air) begin
      idx = '0;
    end else if (hit) begin
      idx = hit_idx;
    end else if (used_q < USED_FULL) begin
      ins = 1'b1;
      idx = NIB_W'(used_q);
    end else begin
      ovf_set = 1'b1;
    end
  end

  // Emission of the voxel's own byte
  logic             s1_emit;
  logic [MAT_W-1:0] uni_next;
  logic [MAT_W-1:0] s1_byte;
  logic             s1_last;
  logic             s1_ovf;

  assign uni_next = (in_occ_q && (uni_q == air_q)) ? in_mat_q : uni_q;

  always_comb begin
    case (mode_q)
      bpme_pkg::MODE_UNIFORM: begin
        s1_emit = in_end_q;
        s1_byte = uni_next;
        s1_last = 1'b1;
        s1_ovf  = 1'b0;
      end
      bpme_pkg::MODE_PALETTE: begin
        s1_emit = parity_q || in_end_q;
        s1_byte = parity_q ? {idx, held_q} : {NIB_W'(0), idx};
        s1_last = 1'b0;
        s1_ovf  = ovf_q || ovf_set;
      end
      default: begin
        s1_emit = 1'b1;
        s1_byte = in_mat_q;
        s1_last = in_end_q;
        s1_ovf  = 1'b0;
      end
    endcase
  end

  assign s1_take = in_v_q && !flush_q && (!s1_emit || out_free);

  // Palette flush sequencing and brick clear
  logic flush_step;
  logic flush_done;
  logic pal_clear;

  assign flush_step = flush_q && out_free;
  assign flush_done = flush_step && (fcnt_q == FLUSH_LAST);
  assign pal_clear  = flush_done || (s1_take && in_end_q && !is_pal);

  always_comb begin
    table_d  = table_q;
    used_d   = used_q;
    ovf_d    = ovf_q;
    held_d   = held_q;
    parity_d = parity_q;
    uni_d    = uni_q;
    flush_d  = flush_q;
    fcnt_d   = fcnt_q;

    // voxel update
    if (s1_take) begin
      if (mode_q == bpme_pkg::MODE_UNIFORM) begin
        uni_d = uni_next;
      end
      if (is_pal) begin
        if (ins) begin
          table_d[used_q[IDX_W-1:0]] = in_mat_q;
          used_d = used_q + USED_W'(1);
        end
        if (ovf_set) begin
          ovf_d = 1'b1;
        end
        held_d   = idx;
        parity_d = !parity_q;
      end
      if (in_end_q) begin
        held_d   = '0;
        parity_d = 1'b0;
        uni_d    = air_q;
        if (is_pal) begin
          flush_d = 1'b1;
          fcnt_d  = '0;
        end
      end
    end

    // flush walk
    if (flush_step) begin
      fcnt_d = fcnt_q + IDX_W'(1);
    end
    if (flush_done) begin
      flush_d = 1'b0;
    end

    if (pal_clear) begin
      for (int k = 0; k < PALETTE_SLOTS; k++) begin
        table_d[k] = '0;
      end
      used_d = USED_RESET;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PALETTE_SLOTS; k++) begin
        table_q[k] <= '0;
      end
      used_q   <= USED_RESET;
      ovf_q    <= 1'b0;
      held_q   <= '0;
      parity_q <= 1'b0;
      uni_q    <= bpme_pkg::AIR_RESET;
      flush_q  <= 1'b0;
      fcnt_q   <= '0;
    end else begin
      table_q  <= table_d;
      used_q   <= used_d;
      ovf_q    <= ovf_d;
      held_q   <= held_d;
      parity_q <= parity_d;
      uni_q    <= uni_d;
      flush_q  <= flush_d;
      fcnt_q   <= fcnt_d;
    end
  end

  // Output register load: voxel byte or palette byte, never both
  always_comb begin
    out_v_d    = out_v_q && out_stall_i;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    if (s1_take && s1_emit) begin
      out_v_d    = 1'b1;
      out_byte_d = s1_byte;
      out_last_d = s1_last;
      out_ovf_d  = s1_ovf;
    end else if (flush_step) begin
      out_v_d    = 1'b1;
      out_byte_d = table_q[fcnt_q];
      out_last_d = (fcnt_q == FLUSH_LAST);
      out_ovf_d  = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o        = out_v_q;
  assign out_byte_o         = out_byte_q;
  assign out_last_o         = out_last_q;
  assign palette_overflow_o = out_ovf_q;

  // Checks
  `BPME_ASSERT(a_flush_holds_input, flush_q |-> !s1_take, "voxel taken during palette flush")
  `BPME_ASSERT(a_used_range, (used_q != '0) && (used_q <= USED_FULL), "palette fill out of range")
  `BPME_ASSERT(a_ovf_only_when_full, ovf_q |-> (used_q == USED_FULL), "overflow with free slots")
  `BPME_ASSERT_NEXT(a_flush_start, s1_take && in_end_q && is_pal, flush_q, "flush did not start")
  `BPME_ASSERT_NEXT(a_flush_clear, flush_done, !flush_q && (used_q == USED_RESET) && !ovf_q, "palette not cleared after flush")

endmodule
